@@ rtl/acpa_pkg.sv @@
// Shared constants, register codes and width helpers for the AC power accumulator.
// Depends on nothing; every other file in rtl imports it.
package acpa_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_SAMPLES = 1024;
	localparam int DEF_SAMPLE_BITS = 12;

	// Configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_OFFSET = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_OFFSET = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_SCALE  = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_SCALE  = 4'd3;

	localparam int OFFSET_W = 12;
	localparam int SCALE_W  = 16;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd2048;
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd4096;

	// Result fields
	localparam int PWR_W       = 52;
	localparam int MS_W        = 40;
	localparam int COUNT_OUT_W = 11;
	localparam int FRAC_SHIFT  = 16;
	localparam logic [PWR_W-1:0] PWR_POS_MAX = {1'b0, {(PWR_W-1){1'b1}}};
	localparam logic [PWR_W-1:0] PWR_NEG_MAG = {1'b1, {(PWR_W-1){1'b0}}};
	localparam logic [MS_W-1:0]  MS_MAX      = {MS_W{1'b1}};

	// Block snapshots held between the accumulator and the finisher
	localparam int QUEUE_DEPTH = 2;

	// Deviation magnitude bits: the wider of sample and offset
	function automatic int acpa_dev_bits(int sample_bits);
		return (sample_bits > OFFSET_W) ? sample_bits : OFFSET_W;
	endfunction

	function automatic int acpa_count_bits(int max_samples);
		return $clog2(max_samples + 1);
	endfunction

	// Unsigned square sum width; the signed product sum is one bit wider
	function automatic int acpa_square_bits(int sample_bits, int max_samples);
		return 2 * acpa_dev_bits(sample_bits) + acpa_count_bits(max_samples);
	endfunction

	function automatic int acpa_entry_bits(int sample_bits, int max_samples);
		return 3 * acpa_square_bits(sample_bits, max_samples) + 2
			+ acpa_count_bits(max_samples);
	endfunction

endpackage

@@ rtl/acpa_front.sv @@
// Sample front end: offset removal, products and block accumulation.
// Depends on acpa_pkg; pushes one snapshot per block into acpa_queue.
module acpa_front
	import acpa_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int ENTRY_W     = acpa_entry_bits(DEF_SAMPLE_BITS, DEF_MAX_SAMPLES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [OFFSET_W-1:0]    voltage_offset,
	input  logic [OFFSET_W-1:0]    current_offset,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] voltage_sample,
	input  logic [SAMPLE_BITS-1:0] current_sample,
	input  logic                   last,
	output logic                   push,
	output logic [ENTRY_W-1:0]     push_data,
	input  logic                   q_full
);

	localparam int DB    = acpa_dev_bits(SAMPLE_BITS);
	localparam int DEV_W = DB + 1;
	localparam int CNT_W = acpa_count_bits(MAX_SAMPLES);
	localparam int SQ_W  = acpa_square_bits(SAMPLE_BITS, MAX_SAMPLES);
	localparam int PS_W  = SQ_W + 1;
	localparam int PRD_W = 2 * DB;
	localparam int XP_W  = 2 * DB + 1;

	logic                    v_s1, v_s2;
	logic                    last_s1, last_s2;
	logic signed [DEV_W-1:0] dv_s1, di_s1;
	logic [PRD_W-1:0]        vsq_s2, isq_s2;
	logic signed [XP_W-1:0]  xp_s2;

	logic signed [2*DEV_W-1:0] vv_full, ii_full, vi_full;

	logic [CNT_W-1:0]       cnt_q, cnt_nx;
	logic signed [PS_W-1:0] psum_q, psum_nx;
	logic [SQ_W-1:0]        vsum_q, vsum_nx, isum_q, isum_nx;
	logic                   at_lim, ends_s2, blk_end, adv;

	assign vv_full = dv_s1 * dv_s1;
	assign ii_full = di_s1 * di_s1;
	assign vi_full = dv_s1 * di_s1;

	assign psum_nx = psum_q + PS_W'(xp_s2);
	assign vsum_nx = vsum_q + SQ_W'(vsq_s2);
	assign isum_nx = isum_q + SQ_W'(isq_s2);
	assign cnt_nx  = cnt_q + CNT_W'(1);

	assign at_lim  = (cnt_nx == CNT_W'(MAX_SAMPLES));
	assign ends_s2 = last_s2 || at_lim;
	assign blk_end = v_s2 && ends_s2;

	// Hold the whole front while a finished block cannot enter the queue
	assign adv          = !(blk_end && q_full);
	assign sample_stall = !adv;
	assign push         = blk_end && !q_full;
	assign push_data    = {psum_nx, vsum_nx, isum_nx, cnt_nx, at_lim};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			cnt_q  <= '0;
			psum_q <= '0;
			vsum_q <= '0;
			isum_q <= '0;
		end else if (adv) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (ends_s2) begin
					cnt_q  <= '0;
					psum_q <= '0;
					vsum_q <= '0;
					isum_q <= '0;
				end else begin
					cnt_q  <= cnt_nx;
					psum_q <= psum_nx;
					vsum_q <= vsum_nx;
					isum_q <= isum_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s1   <= $signed({1'b0, DB'(voltage_sample)}) - $signed({1'b0, DB'(voltage_offset)});
			di_s1   <= $signed({1'b0, DB'(current_sample)}) - $signed({1'b0, DB'(current_offset)});
			last_s1 <= last;
			vsq_s2  <= vv_full[PRD_W-1:0];
			isq_s2  <= ii_full[PRD_W-1:0];
			xp_s2   <= vi_full[XP_W-1:0];
			last_s2 <= last_s1;
		end
	end

`ifndef SYNTH
	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(MAX_SAMPLES))
		else $error("pair count reached the block limit without closing the block");
`endif

endmodule

@@ rtl/acpa_queue.sv @@
// Short register queue of block snapshots between the front end and the finisher.
// Depends on acpa_pkg for the default depth.
module acpa_queue
	import acpa_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("snapshot pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("snapshot popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy above depth");
`endif

endmodule

@@ rtl/acpa_back.sv @@
// Block finisher: scaling by a shared bit-serial multiplier, mean by a radix-2 divider.
// Depends on acpa_pkg; takes snapshots from acpa_queue and drives the result channel.
module acpa_back
	import acpa_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int ENTRY_W     = acpa_entry_bits(DEF_SAMPLE_BITS, DEF_MAX_SAMPLES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [SCALE_W-1:0]      voltage_scale,
	input  logic [SCALE_W-1:0]      current_scale,
	input  logic                    q_valid,
	output logic                    pop,
	input  logic [ENTRY_W-1:0]      pop_data,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [PWR_W-1:0] real_power,
	output logic [MS_W-1:0]         voltage_mean_square,
	output logic [MS_W-1:0]         current_mean_square,
	output logic [COUNT_OUT_W-1:0]  sample_count,
	output logic                    ended_by_limit
);

	localparam int CNT_W  = acpa_count_bits(MAX_SAMPLES);
	localparam int SQ_W   = acpa_square_bits(SAMPLE_BITS, MAX_SAMPLES);
	localparam int PS_W   = SQ_W + 1;
	localparam int MAG_W  = SQ_W;
	localparam int SP_W   = 2 * SCALE_W;
	localparam int PROD_W = MAG_W + SP_W;
	localparam int DW     = PROD_W - FRAC_SHIFT;
	localparam int HI_W   = DW - MS_W;
	localparam int EXT_W  = (DW > PWR_W + 1) ? DW : PWR_W + 1;
	localparam int STEP_W = $clog2((MS_W > SP_W) ? MS_W : SP_W);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_POST  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [1:0] OP_PWR = 2'd0;
	localparam logic [1:0] OP_VMS = 2'd1;
	localparam logic [1:0] OP_IMS = 2'd2;

	logic [2:0]        state_q;
	logic [1:0]        op_q;
	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;

	logic signed [PS_W-1:0] e_psum;
	logic [SQ_W-1:0]        e_vsum, e_isum;
	logic [CNT_W-1:0]       e_n;
	logic                   e_lim;

	logic signed [PS_W-1:0] psum_q, psum_neg;
	logic [SQ_W-1:0]        vsum_q, isum_q;
	logic [CNT_W-1:0]       n_q;
	logic                   lim_q;

	logic [SP_W-1:0]    sprod_q;
	logic [MAG_W-1:0]   mcand_q, op_mag;
	logic [PROD_W-1:0]  prod_q, mul_nx;
	logic [SCALE_W-1:0] sc_a, sc_b;

	logic [DW-1:0]    d;
	logic [EXT_W-1:0] dx;
	logic [HI_W-1:0]  hi;
	logic             ms_sat, pwr_neg;
	logic [PWR_W-1:0] neg_mag, pos_val, pwr_val;

	logic [CNT_W-1:0] rem_q, rem_nx;
	logic [MS_W-1:0]  quo_q, quo_nx;
	logic [CNT_W:0]   r2, diff;
	logic             ge;

	logic signed [PWR_W-1:0] pwr_q, out_pwr_q;
	logic [MS_W-1:0]         vms_q, ims_q, out_vms_q, out_ims_q;
	logic [CNT_W-1:0]        out_n_q;
	logic                    out_lim_q;
	logic                    out_free;

	assign {e_psum, e_vsum, e_isum, e_n, e_lim} = pop_data;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign out_free = !res_valid_q || !result_stall;

	// Operand selection for the current pass
	assign sc_a     = (op_q == OP_IMS) ? current_scale : voltage_scale;
	assign sc_b     = (op_q == OP_VMS) ? voltage_scale : current_scale;
	assign psum_neg = -psum_q;
	always_comb begin
		case (op_q)
			OP_PWR:  op_mag = psum_q[PS_W-1] ? psum_neg[MAG_W-1:0] : psum_q[MAG_W-1:0];
			OP_VMS:  op_mag = vsum_q;
			default: op_mag = isum_q;
		endcase
	end

	// One scale bit per cycle, most significant first
	assign mul_nx = {prod_q[PROD_W-2:0], 1'b0}
		+ (sprod_q[SP_W-1] ? PROD_W'(mcand_q) : PROD_W'(0));

	// Drop the Q.16 fraction, then saturate power to its signed range
	assign d       = prod_q[PROD_W-1:FRAC_SHIFT];
	assign dx      = EXT_W'(d);
	assign pwr_neg = psum_q[PS_W-1];
	assign neg_mag = (dx > EXT_W'(PWR_NEG_MAG)) ? PWR_NEG_MAG : dx[PWR_W-1:0];
	assign pos_val = (dx > EXT_W'(PWR_POS_MAX)) ? PWR_POS_MAX : dx[PWR_W-1:0];
	assign pwr_val = pwr_neg ? (PWR_W'(0) - neg_mag) : pos_val;

	// Quotient cannot fit in MS_W bits when the upper part already reaches n
	assign hi     = d[DW-1:MS_W];
	assign ms_sat = (hi >= HI_W'(n_q));

	// Restoring division step
	assign r2     = {rem_q, quo_q[MS_W-1]};
	assign ge     = (r2 >= {1'b0, n_q});
	assign diff   = r2 - {1'b0, n_q};
	assign rem_nx = ge ? diff[CNT_W-1:0] : r2[CNT_W-1:0];
	assign quo_nx = {quo_q[MS_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PWR;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q    <= OP_PWR;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					step_q  <= STEP_W'(SP_W - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (step_q == '0) begin
						state_q <= ST_POST;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_POST: begin
					if (op_q == OP_PWR) begin
						op_q    <= OP_VMS;
						state_q <= ST_SETUP;
					end else if (ms_sat) begin
						if (op_q == OP_IMS) begin
							state_q <= ST_OUT;
						end else begin
							op_q    <= OP_IMS;
							state_q <= ST_SETUP;
						end
					end else begin
						step_q  <= STEP_W'(MS_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						if (op_q == OP_IMS) begin
							state_q <= ST_OUT;
						end else begin
							op_q    <= OP_IMS;
							state_q <= ST_SETUP;
						end
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					psum_q <= e_psum;
					vsum_q <= e_vsum;
					isum_q <= e_isum;
					n_q    <= e_n;
					lim_q  <= e_lim;
				end
			end
			ST_SETUP: begin
				sprod_q <= SP_W'(sc_a) * SP_W'(sc_b);
				mcand_q <= op_mag;
				prod_q  <= '0;
			end
			ST_MUL: begin
				prod_q  <= mul_nx;
				sprod_q <= {sprod_q[SP_W-2:0], 1'b0};
			end
			ST_POST: begin
				if (op_q == OP_PWR) begin
					pwr_q <= pwr_val;
				end else if (ms_sat) begin
					if (op_q == OP_VMS) begin
						vms_q <= MS_MAX;
					end else begin
						ims_q <= MS_MAX;
					end
				end else begin
					rem_q <= hi[CNT_W-1:0];
					quo_q <= d[MS_W-1:0];
				end
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (step_q == '0) begin
					if (op_q == OP_VMS) begin
						vms_q <= quo_nx;
					end else begin
						ims_q <= quo_nx;
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_pwr_q <= pwr_q;
					out_vms_q <= vms_q;
					out_ims_q <= ims_q;
					out_n_q   <= n_q;
					out_lim_q <= lim_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid        = res_valid_q;
	assign real_power          = out_pwr_q;
	assign voltage_mean_square = out_vms_q;
	assign current_mean_square = out_ims_q;
	assign sample_count        = COUNT_OUT_W'(out_n_q);
	assign ended_by_limit      = out_lim_q;

`ifndef SYNTH
	a_div_only_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (op_q != OP_PWR))
		else $error("divider running on the power pass");
	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && !out_free) |=> (state_q == ST_OUT))
		else $error("finisher left the output step while the result register was busy");
`endif

endmodule

@@ rtl/ac_power_accumulator_core.sv @@
// Top level of the AC power accumulator: configuration registers and the three parts.
// Depends on acpa_pkg, acpa_front, acpa_queue and acpa_back.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+---------------------------------------------
//  sample   | sample_valid | sample_stall | voltage_sample, current_sample, last
//  result   | result_valid | result_stall | real_power, voltage_mean_square,
//           |              |              | current_mean_square, sample_count,
//           |              |              | ended_by_limit
//  config   | cfg_wr_en    | (none)       | cfg_index, cfg_wdata
//
// Flow: one sample pair per cycle while sample_stall is low; deviations, products, sums
// are registered in turn. The finisher pops each block, runs three passes of the shared
// 32-step multiplier, up to two 40-step divisions, output load; two snapshots queue ahead.
// Reset: arst_n clears all control state and accumulators and loads register defaults.
// Stalls: result_stall holds the output register and the finisher at its output load;
// it works ahead a block; samples stall only when a block closes with the queue full.
module ac_power_accumulator_core
	import acpa_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic [SAMPLE_BITS-1:0]  voltage_sample,
	input  logic [SAMPLE_BITS-1:0]  current_sample,
	input  logic                    last,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [PWR_W-1:0] real_power,
	output logic [MS_W-1:0]         voltage_mean_square,
	output logic [MS_W-1:0]         current_mean_square,
	output logic [COUNT_OUT_W-1:0]  sample_count,
	output logic                    ended_by_limit
);

	// One queue entry: signed product sum, two square sums, pair count, limit flag
	localparam int ENTRY_W = acpa_entry_bits(SAMPLE_BITS, MAX_SAMPLES);

	logic [OFFSET_W-1:0] v_off_q, i_off_q;
	logic [SCALE_W-1:0]  v_scale_q, i_scale_q;

	logic               push, q_full, pop, q_valid;
	logic [ENTRY_W-1:0] push_data, pop_data;

	// Configuration writes; indexes past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_off_q   <= OFFSET_RESET;
			i_off_q   <= OFFSET_RESET;
			v_scale_q <= SCALE_RESET;
			i_scale_q <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_VOLTAGE_OFFSET: v_off_q   <= cfg_wdata[OFFSET_W-1:0];
				REG_CURRENT_OFFSET: i_off_q   <= cfg_wdata[OFFSET_W-1:0];
				REG_VOLTAGE_SCALE:  v_scale_q <= cfg_wdata[SCALE_W-1:0];
				REG_CURRENT_SCALE:  i_scale_q <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: remove offsets, form products, accumulate, close blocks
	acpa_front #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.voltage_offset (v_off_q),
		.current_offset (i_off_q),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.voltage_sample (voltage_sample),
		.current_sample (current_sample),
		.last           (last),
		.push           (push),
		.push_data      (push_data),
		.q_full         (q_full)
	);

	// Snapshot queue decouples sample intake from the slow finisher
	acpa_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (pop_data)
	);

	// Back: scale, divide by the count, saturate, present the result
	acpa_back #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.voltage_scale       (v_scale_q),
		.current_scale       (i_scale_q),
		.q_valid             (q_valid),
		.pop                 (pop),
		.pop_data            (pop_data),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.real_power          (real_power),
		.voltage_mean_square (voltage_mean_square),
		.current_mean_square (current_mean_square),
		.sample_count        (sample_count),
		.ended_by_limit      (ended_by_limit)
	);

endmodule

@@ tb/sv/tb_ac_power_accumulator_core.sv @@
// Self-checking testbench for ac_power_accumulator_core: random and directed sample-pair
// blocks under several register settings, checked by an in-bench power/mean-square model.
// Depends on acpa_pkg and the ac_power_accumulator_core RTL only.
module tb_ac_power_accumulator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import acpa_pkg::*;

	localparam int SB        = DEF_SAMPLE_BITS;
	localparam int MAX_PAIRS = DEF_MAX_SAMPLES;
	localparam int NUM_REGS  = 4;
	// Finisher runs three multiplier passes per block and two snapshots can wait ahead of it
	localparam int SETTLE_CYCLES = 700;
	localparam logic [63:0] MS_SCALED_CAP = 64'd1 << 57;
	localparam logic [SB-1:0] SAMPLE_TOP = {SB{1'b1}};

	typedef struct packed {
		logic [SB-1:0] v;
		logic [SB-1:0] i;
		logic          lst;
	} sample_pair_t;

	typedef struct {
		logic signed [PWR_W-1:0] power;
		logic [MS_W-1:0]         v_ms;
		logic [MS_W-1:0]         i_ms;
		logic [COUNT_OUT_W-1:0]  count;
		logic                    by_limit;
	} power_reading_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	logic [SB-1:0]           voltage_sample = '0;
	logic [SB-1:0]           current_sample = '0;
	logic                    last = 1'b0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic signed [PWR_W-1:0] real_power;
	logic [MS_W-1:0]         voltage_mean_square;
	logic [MS_W-1:0]         current_mean_square;
	logic [COUNT_OUT_W-1:0]  sample_count;
	logic                    ended_by_limit;

	// Stimulus and scoreboard storage
	sample_pair_t   queued_pairs[$];
	power_reading_t expected_readings[$];
	sample_pair_t   next_pair;
	int             mismatch_count = 0;
	bit             sample_taken = 1'b0;
	int             send_gap = 0;
	int             send_quiet = 0;
	int             stall_left = 0;
	int             stall_quiet = 0;

	// Predictor copy of the registers and accumulators
	longint         volt_offset = OFFSET_RESET;
	longint         curr_offset = OFFSET_RESET;
	logic [63:0]    volt_gain = SCALE_RESET;
	logic [63:0]    curr_gain = SCALE_RESET;
	int             pair_total = 0;
	longint         product_acc = 0;
	logic [63:0]    volt_sq_acc = 64'd0;
	logic [63:0]    curr_sq_acc = 64'd0;

	ac_power_accumulator_core dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.sample_valid        (sample_valid),
		.sample_stall        (sample_stall),
		.voltage_sample      (voltage_sample),
		.current_sample      (current_sample),
		.last                (last),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.real_power          (real_power),
		.voltage_mean_square (voltage_mean_square),
		.current_mean_square (current_mean_square),
		.sample_count        (sample_count),
		.ended_by_limit      (ended_by_limit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// floor(m * s / 2^16), clipped at cap; the product is taken at 128 bits
	function automatic logic [63:0] scale_floor(logic [63:0] m, logic [63:0] s,
			logic [63:0] cap);
		logic [127:0] w;
		w = {64'd0, m} * {64'd0, s};
		w = w >> FRAC_SHIFT;
		return (w > {64'd0, cap}) ? cap : w[63:0];
	endfunction

	function automatic logic [MS_W-1:0] mean_square_of(logic [63:0] sum, logic [63:0] gain,
			logic [63:0] n);
		logic [63:0] q;
		q = scale_floor(sum, gain * gain, MS_SCALED_CAP) / n;
		return (q > {24'd0, MS_MAX}) ? MS_MAX : q[MS_W-1:0];
	endfunction

	// Fold one accepted pair into the accumulators; close the block on last or at the limit
	task automatic accumulate_pair(input logic [SB-1:0] vs, input logic [SB-1:0] cs,
			input logic lst);
		longint         dv;
		longint         di;
		logic [63:0]    mag;
		logic [63:0]    pw;
		logic [63:0]    neg_pw;
		power_reading_t r;
		bit             at_limit;
		dv = vs;
		di = cs;
		dv = dv - volt_offset;
		di = di - curr_offset;
		product_acc = product_acc + dv * di;
		volt_sq_acc = volt_sq_acc + dv * dv;
		curr_sq_acc = curr_sq_acc + di * di;
		pair_total++;
		at_limit = (pair_total >= MAX_PAIRS);
		if (lst || at_limit) begin
			mag = (product_acc < 0) ? -product_acc : product_acc;
			pw = scale_floor(mag, volt_gain * curr_gain, {12'd0, PWR_NEG_MAG});
			if (product_acc < 0) begin
				neg_pw = -pw;
				r.power = neg_pw[PWR_W-1:0];
			end else begin
				r.power = (pw > {12'd0, PWR_POS_MAX}) ? PWR_POS_MAX : pw[PWR_W-1:0];
			end
			r.v_ms = mean_square_of(volt_sq_acc, volt_gain, 64'(pair_total));
			r.i_ms = mean_square_of(curr_sq_acc, curr_gain, 64'(pair_total));
			r.count = pair_total[COUNT_OUT_W-1:0];
			r.by_limit = at_limit;
			expected_readings.push_back(r);
			pair_total = 0;
			product_acc = 0;
			volt_sq_acc = 64'd0;
			curr_sq_acc = 64'd0;
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	task automatic check_reading();
		power_reading_t want;
		if (expected_readings.size() == 0) begin
			mismatch_count++;
			$display("%0t ns: result with nothing expected, real_power %h, sample_count %0d",
				$time, real_power, sample_count);
		end else begin
			want = expected_readings.pop_front();
			compare_field("real_power", want.power, real_power);
			compare_field("voltage_mean_square", want.v_ms, voltage_mean_square);
			compare_field("current_mean_square", want.i_ms, current_mean_square);
			compare_field("sample_count", want.count, sample_count);
			compare_field("ended_by_limit", want.by_limit, ended_by_limit);
		end
	endtask

	// Monitor: track register writes, predict on each accepted sample transaction, then
	// check each accepted result transaction. Prediction goes first so a push and a pop
	// in the same edge never see a stale queue. The taken flag tells the driver at the
	// next falling edge whether its transaction has gone.
	always @(posedge clk) begin
		sample_taken = arst_n && sample_valid && !sample_stall;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_VOLTAGE_OFFSET: volt_offset = cfg_wdata[OFFSET_W-1:0];
					REG_CURRENT_OFFSET: curr_offset = cfg_wdata[OFFSET_W-1:0];
					REG_VOLTAGE_SCALE:  volt_gain = cfg_wdata[SCALE_W-1:0];
					REG_CURRENT_SCALE:  curr_gain = cfg_wdata[SCALE_W-1:0];
					default: ;
				endcase
			end
			if (sample_taken)
				accumulate_pair(voltage_sample, current_sample, last);
			if (result_valid && !result_stall)
				check_reading();
		end
	end

	// Driver: present the next queued pair once the previous transaction has gone,
	// optionally idling first. A stalled payload is held untouched.
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || sample_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				sample_valid <= 1'b0;
			end else if (queued_pairs.size() != 0) begin
				next_pair = queued_pairs.pop_front();
				voltage_sample <= next_pair.v;
				current_sample <= next_pair.i;
				last <= next_pair.lst;
				sample_valid <= 1'b1;
				// Stretches without idling come from the quiet counter
				if (send_quiet > 0) begin
					send_quiet--;
					send_gap = 0;
				end else begin
					send_gap = pick_gap();
					if ($urandom_range(0, 99) == 0)
						send_quiet = $urandom_range(30, 200);
				end
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Result back-pressure: random stall bursts with quiet stretches in between
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (stall_quiet > 0) begin
				stall_quiet--;
			end else begin
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
				if ($urandom_range(0, 199) == 0)
					stall_quiet = $urandom_range(30, 150);
			end
		end
	end

	task automatic queue_pair(input logic [SB-1:0] v, input logic [SB-1:0] i,
			input logic lst);
		sample_pair_t p;
		p.v = v;
		p.i = i;
		p.lst = lst;
		queued_pairs.push_back(p);
	endtask

	// Mostly uniform, with extra weight on the rails and on the mid-scale
	function automatic logic [SB-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 16) return SAMPLE_TOP;
		if (r < 24) return SB'((SAMPLE_TOP >> 1) + $urandom_range(0, 16) - 8);
		return SB'($urandom_range(0, SAMPLE_TOP));
	endfunction

	// Block lengths: mostly short, a few long ones up to the limit
	function automatic int pick_block_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return $urandom_range(1, 8);
		if (r < 90) return $urandom_range(9, 40);
		if (r < 99) return $urandom_range(41, 200);
		return $urandom_range(201, MAX_PAIRS);
	endfunction

	task automatic queue_random_blocks(input int target);
		int done;
		int len;
		done = 0;
		while (done < target) begin
			len = pick_block_len();
			for (int k = 0; k < len; k++)
				queue_pair(rand_sample(), rand_sample(), k == len - 1);
			done += len;
		end
	endtask

	// Constant-content block, with or without last on its final pair
	task automatic queue_constant_block(input int len, input logic [SB-1:0] v,
			input logic [SB-1:0] i, input logic end_last);
		for (int k = 0; k < len; k++)
			queue_pair(v, i, end_last && (k == len - 1));
	endtask

	// Hold off until the sender is drained and every expected result is in, then let
	// the finisher run dry before anything else happens
	task automatic settle();
		while (queued_pairs.size() != 0 || sample_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
	endtask

	// Load all four registers plus one stray write to an unused index
	task automatic apply_config(input logic [CFG_DATA_W-1:0] v_off,
			input logic [CFG_DATA_W-1:0] i_off, input logic [CFG_DATA_W-1:0] v_scale,
			input logic [CFG_DATA_W-1:0] i_scale);
		write_reg(REG_VOLTAGE_OFFSET, v_off);
		write_reg(REG_CURRENT_OFFSET, i_off);
		write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, 2 ** CFG_INDEX_W - 1)),
			CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)));
		write_reg(REG_VOLTAGE_SCALE, v_scale);
		write_reg(REG_CURRENT_SCALE, i_scale);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: single- and multi-pair blocks at the rails, zero deviation, sign mixes
		queue_pair(SAMPLE_TOP, SAMPLE_TOP, 1'b1);
		queue_pair('0, '0, 1'b1);
		queue_pair('0, SAMPLE_TOP, 1'b1);
		queue_pair(SAMPLE_TOP, '0, 1'b1);
		queue_pair(SB'(OFFSET_RESET), SB'(OFFSET_RESET), 1'b1);
		queue_pair(SAMPLE_TOP, '0, 1'b0);
		queue_pair('0, SAMPLE_TOP, 1'b1);
		queue_pair(SB'(1), SAMPLE_TOP - SB'(1), 1'b0);
		queue_pair(SB'(OFFSET_RESET) - SB'(1), SB'(OFFSET_RESET) + SB'(1), 1'b0);
		queue_pair(SAMPLE_TOP, SAMPLE_TOP, 1'b0);
		queue_pair('0, '0, 1'b1);
		queue_random_blocks(120);
		settle();

		// Offsets zero (upper data bits must be dropped), full-scale gains
		apply_config(16'hF000, 16'h0000, 16'hFFFF, 16'hFFFF);
		queue_pair(SAMPLE_TOP, SAMPLE_TOP, 1'b1);
		queue_pair('0, '0, 1'b1);
		queue_pair(SAMPLE_TOP, '0, 1'b1);
		queue_random_blocks(80);
		settle();

		// Voltage offset at the top: most negative product sum and largest square sums,
		// limit and last together
		apply_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		queue_pair('0, SAMPLE_TOP, 1'b1);
		queue_constant_block(MAX_PAIRS, '0, SAMPLE_TOP, 1'b1);
		queue_random_blocks(80);
		settle();

		// Zero gains: every scaled field must come out zero
		apply_config(CFG_DATA_W'($urandom_range(0, 65535)),
			CFG_DATA_W'($urandom_range(0, 65535)), 16'h0000, 16'h0000);
		queue_random_blocks(60);
		settle();

		// Smallest nonzero gains, offsets at opposite rails
		apply_config(16'h0FFF, 16'h0000, 16'h0001, 16'h0001);
		queue_random_blocks(60);
		settle();

		// Random settings
		repeat (4) begin
			apply_config(CFG_DATA_W'($urandom_range(0, 65535)),
				CFG_DATA_W'($urandom_range(0, 65535)),
				CFG_DATA_W'($urandom_range(0, 65535)),
				CFG_DATA_W'($urandom_range(0, 65535)));
			queue_random_blocks(40);
			settle();
		end

		// Back to the reset values, written explicitly
		apply_config(CFG_DATA_W'(OFFSET_RESET), CFG_DATA_W'(OFFSET_RESET),
			SCALE_RESET, SCALE_RESET);
		queue_random_blocks(50);
		settle();

		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
